// ===== src/ttip_pkg.sv =====
package ttip_pkg;

    localparam int MAX_LEN_DEF = 255;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int BASE_W     = 6;
    localparam int DIGIT_W    = 6;
    localparam int VALUE_W    = 64;
    localparam int OFFSET_W   = 8;
    localparam int CHAR_W     = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE   = 2'd2;

    // Characters and radix constants.
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_X   = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    localparam logic [DIGIT_W-1:0] NO_DIGIT = 6'd36;

    typedef struct packed {
        logic [BASE_W-1:0] base_select;
        logic              signed_mode;
        logic              wide_mode;
    } t_cfg;

    typedef struct packed {
        logic [OFFSET_W-1:0] end_offset;
        logic [VALUE_W-1:0]  value;
    } t_result;

    // Digit value of a character: 0-9, then letters of either case as 10-35.
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = DIGIT_W'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = DIGIT_W'(c - CH_LO_A + 8'd10);
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = DIGIT_W'(c - CH_UP_A + 8'd10);
        end
        return d;
    endfunction

endpackage

// ===== src/ttip_in_reg.sv =====
module ttip_in_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_start,
    input  logic [ttip_pkg::CHAR_W-1:0] i_char,
    input  logic                        i_take,
    output logic                        o_valid,
    output logic                        o_start,
    output logic [ttip_pkg::CHAR_W-1:0] o_char
);
    import ttip_pkg::*;

    logic              r_valid;
    logic              r_start;
    logic [CHAR_W-1:0] r_char;

    // The register frees up in the same cycle its beat is consumed.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_start <= i_start;
            r_char  <= i_char;
        end
    end

    assign o_valid = r_valid;
    assign o_start = r_start;
    assign o_char  = r_char;
endmodule

// ===== src/ttip_core.sv =====
module ttip_core #(
    parameter int MAX_LEN = ttip_pkg::MAX_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic                        i_start,
    input  logic [ttip_pkg::CHAR_W-1:0] i_char,
    input  ttip_pkg::t_cfg              i_cfg,
    output logic                        o_res_valid,
    output ttip_pkg::t_result           o_res
);
    import ttip_pkg::*;

    localparam int PW  = $clog2(MAX_LEN + 1);
    localparam int EXW = 17;
    localparam int PRW = VALUE_W + BASE_W + 1;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_LEAD   = 2'd1;
    localparam logic [1:0] PH_ZERO   = 2'd2;
    localparam logic [1:0] PH_DIGITS = 2'd3;

    logic [1:0]         r_phase,    n_phase;
    logic               r_negative, n_negative;
    logic [BASE_W-1:0]  r_base,     n_base;
    logic [VALUE_W-1:0] r_acc,      n_acc;
    logic [PW-1:0]      r_pos,      n_pos;

    logic [DIGIT_W-1:0] dig;
    logic [VALUE_W-1:0] limit;
    logic [PRW-1:0]     prod;
    logic               take;
    logic               fin;
    logic               dig_step;
    logic [EXW-1:0]     pos_ext;

    assign dig = digit_of(i_char);

    always_comb begin
        n_phase    = r_phase;
        n_negative = r_negative;
        n_base     = r_base;
        n_acc      = r_acc;
        n_pos      = r_pos;
        take       = 1'b0;
        fin        = 1'b0;
        dig_step   = 1'b0;
        limit      = '0;
        prod       = '0;
        pos_ext    = '0;
        o_res      = '0;

        if (i_start) begin
            n_phase    = PH_LEAD;
            n_negative = 1'b0;
            n_base     = BASE_AUTO;
            n_acc      = '0;
            n_pos      = '0;
            if (i_cfg.signed_mode && (i_char == CH_MINUS || i_char == CH_PLUS)) begin
                n_negative = (i_char == CH_MINUS);
                n_pos      = PW'(1);
            end else begin
                take = 1'b1;
            end
        end else if (r_phase != PH_IDLE) begin
            take = 1'b1;
        end

        if (take) begin
            if (n_pos >= PW'(MAX_LEN)) begin
                fin = 1'b1;
            end else begin
                dig_step = 1'b1;
                if (n_phase == PH_LEAD) begin
                    if (i_char == CH_ZERO) begin
                        n_phase  = PH_ZERO;
                        n_pos    = n_pos + PW'(1);
                        dig_step = 1'b0;
                    end else begin
                        n_base  = (i_cfg.base_select != BASE_AUTO) ? i_cfg.base_select
                                                                   : BASE_DEC;
                        n_phase = PH_DIGITS;
                    end
                end else if (n_phase == PH_ZERO) begin
                    dig_step = 1'b0;
                    if (i_char == CH_LO_X || i_char == CH_UP_X) begin
                        if (i_cfg.base_select != BASE_AUTO && i_cfg.base_select != BASE_HEX) begin
                            // A hex prefix under a foreign base yields zero at the x.
                            n_acc = '0;
                            fin   = 1'b1;
                        end else begin
                            n_base  = BASE_HEX;
                            n_phase = PH_DIGITS;
                            n_pos   = n_pos + PW'(1);
                        end
                    end else begin
                        n_base   = (i_cfg.base_select != BASE_AUTO) ? i_cfg.base_select
                                                                    : BASE_OCT;
                        n_phase  = PH_DIGITS;
                        dig_step = 1'b1;
                    end
                end

                if (dig_step) begin
                    if (i_cfg.signed_mode) begin
                        if (i_cfg.wide_mode) begin
                            limit = n_negative ? 64'h8000_0000_0000_0000
                                               : 64'h7FFF_FFFF_FFFF_FFFF;
                        end else begin
                            limit = n_negative ? 64'h0000_0000_8000_0000
                                               : 64'h0000_0000_7FFF_FFFF;
                        end
                    end else begin
                        limit = i_cfg.wide_mode ? 64'hFFFF_FFFF_FFFF_FFFF
                                                : 64'h0000_0000_FFFF_FFFF;
                    end
                    // acc > (limit - d) / base is the same test as acc * base + d > limit.
                    prod = PRW'(n_acc) * PRW'(n_base) + PRW'(dig);
                    if (dig >= n_base || prod > PRW'(limit)) begin
                        fin = 1'b1;
                    end else begin
                        n_acc = prod[VALUE_W-1:0];
                        n_pos = n_pos + PW'(1);
                    end
                end
            end
        end

        if (fin) begin
            n_phase          = PH_IDLE;
            pos_ext          = EXW'(n_pos);
            o_res.value      = n_negative ? (VALUE_W'(0) - n_acc) : n_acc;
            o_res.end_offset = (pos_ext > EXW'(255)) ? {OFFSET_W{1'b1}}
                                                     : pos_ext[OFFSET_W-1:0];
        end
    end

    assign o_res_valid = i_fire && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_negative <= 1'b0;
            r_base     <= BASE_AUTO;
            r_acc      <= '0;
            r_pos      <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_negative <= n_negative;
            r_base     <= n_base;
            r_acc      <= n_acc;
            r_pos      <= n_pos;
        end
    end
endmodule

// ===== src/ttip_out_reg.sv =====
module ttip_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ttip_pkg::t_result i_res,
    output logic              o_can_take,
    output logic              o_valid,
    input  logic              i_ready,
    output ttip_pkg::t_result o_res
);
    import ttip_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_take = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

// ===== src/text_to_integer_parser_top.sv =====
// Channel     Direction  Ports                          Contents
// ----------  ---------  -----------------------------  ---------------------------------
// s_axis      in         tvalid/tready/tdata/tuser      one character per beat
// m_axis      out        tvalid/tready/tdata            parsed value and stop offset
// cfg         in         i_cfg_valid/o_cfg_ready/...    register index and write data
//
// Each character beat is registered on entry; then one pass of digit decode, a 64 by 6
// bit multiply-add and the overflow compare updates the parse state and, on the stopping
// character, loads the result register. A new beat is accepted every cycle as long as
// the result register is empty or being drained. A stopping character passes the input
// register and then the result register, from which its result beat is presented.
// Reset is synchronous and active low; it clears the parse state and sets the
// registers to automatic base, signed mode and 64-bit limits.
// Configuration writes are always accepted and act on the next character processed.
module text_to_integer_parser_top #(
    parameter int MAX_LEN = ttip_pkg::MAX_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] char_code
    input  logic                            s_axis_tuser,   // [0] start_req

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [71:0]                     m_axis_tdata,   // [63:0] value, [71:64] end_offset

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ttip_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ttip_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ttip_pkg::*;

    t_cfg              r_cfg;
    logic              in_valid;
    logic              in_start;
    logic [CHAR_W-1:0] in_char;
    logic              fire;
    logic              out_can_take;
    logic              res_valid;
    t_result           res;
    t_result           out_res;

    // Configuration registers; an index past the list is accepted and dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_select <= BASE_AUTO;
            r_cfg.signed_mode <= 1'b1;
            r_cfg.wide_mode   <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BASE_SELECT: r_cfg.base_select <= i_cfg_data[BASE_W-1:0];
                CFG_SIGNED_MODE: r_cfg.signed_mode <= i_cfg_data[0];
                CFG_WIDE_MODE:   r_cfg.wide_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    ttip_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_start (s_axis_tuser),
        .i_char  (s_axis_tdata),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_start (in_start),
        .o_char  (in_char)
    );

    // A registered character is processed whenever the result register can absorb
    // whatever it may produce; characters that end nothing still need the slot free.
    assign fire = in_valid && out_can_take;

    ttip_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_start     (in_start),
        .i_char      (in_char),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ttip_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .o_can_take (out_can_take),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (out_res)
    );

    assign m_axis_tdata = {out_res.end_offset, out_res.value};
endmodule
